/* hdl/assert_macros.svh */
// Assertion macros shared by the modules that check their own behaviour.
// Depends on nothing; each user supplies signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/ebsp_pkg.sv */
// Types, constants and a helper function of the element stream parser.
// Depends on nothing; used by every module of the block.
package ebsp_pkg;

    localparam int MAX_DEPTH  = 8;
    localparam int POS_BITS   = 48;
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W      = ((POS_BITS > 56) ? POS_BITS : 56) + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [31:0] ID_HEADER   = 32'h1A45DFA3;
    localparam logic [31:0] ID_SEGMENT  = 32'h18538067;
    localparam logic [31:0] ID_TRACKS   = 32'h1654AE6B;
    localparam logic [31:0] ID_ENTRY    = 32'h000000AE;
    localparam logic [31:0] ID_VIDEO    = 32'h000000E0;
    localparam logic [31:0] ID_PIX_W    = 32'h000000B0;
    localparam logic [31:0] ID_PIX_H    = 32'h000000BA;
    localparam logic [7:0]  ID_MIN_BYTE = 8'h10;

    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_WIDTH    = 3'd1,
        K_HEIGHT   = 3'd2,
        K_BAD_ID   = 3'd3,
        K_BAD_SIZE = 3'd4,
        K_TRUNC    = 3'd5,
        K_DEEP     = 3'd6
    } kind_t;

    typedef enum logic [6:0] {
        PH_ID_FIRST   = 7'b0000001,
        PH_ID_MORE    = 7'b0000010,
        PH_SIZE_FIRST = 7'b0000100,
        PH_SIZE_MORE  = 7'b0001000,
        PH_SKIP       = 7'b0010000,
        PH_PIXEL      = 7'b0100000,
        PH_HALT       = 7'b1000000
    } phase_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  elem_id;
        logic [2:0]   id_bytes;
        logic [55:0]  element_size;
        logic [3:0]   size_bytes;
        logic [3:0]   nest_level;
        logic [63:0]  pixel_value;
    } res_t;

    typedef struct packed {
        logic                push;
        logic                pop_en;
        logic [POS_BITS-1:0] push_end;
        logic [POS_BITS-1:0] npos;
    } cell_ctl_t;

    function automatic logic [3:0] lead_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i] && n == 4'd8)
            begin
                n = 4'(8 - i);
            end
        end
        if (b[0] == 1'b0 && b[7:1] == 7'd0)
        begin
            n = 4'd8;
        end
        return n;
    endfunction

endpackage

/* hdl/ebml_element_stream_parser.sv */
// Top level of the element stream parser: byte decoder, container stack cells
// and result queue. Depends on ebsp_pkg, ebsp_cell, ebsp_res_fifo and the macros.
//
// Usage: bytes of a container file enter on data_byte/last_byte with
// in_valid/in_ready; each transfer is one byte. Results leave on the
// kind..pixel_value ports with out_valid/out_ready, one per transfer.
// One byte is taken every cycle while in_ready is high; a byte yields zero, one or two results.
// A result is registered in the queue as its byte is taken and offered once earlier results have left.
// The stack end positions are compared against the byte position in all
// cells at once, so a byte that closes several levels does not hold off the byte stream.
// Results wait in a four-entry queue; in_ready drops while fewer than two
// entries are free, so a stalled receiver holds off the byte stream.
// After an error result, or after the final byte, every further byte is
// consumed without result until reset.
// Reset empties the queue, closes all levels and returns to expecting an ID.
module ebml_element_stream_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             kind,
    output logic [31:0]            elem_id,
    output logic [2:0]             id_bytes,
    output logic [55:0]            element_size,
    output logic [3:0]             size_bytes,
    output logic [3:0]             nest_level,
    output logic [63:0]            pixel_value
);
    import ebsp_pkg::*;
`include "assert_macros.svh"

    phase_t              phase_reg, phase_next, ph_n;
    logic [31:0]         id_reg, id_next;
    logic [2:0]          idlen_reg, idlen_next;
    logic [1:0]          idleft_reg, idleft_next;
    logic [55:0]         size_reg, size_next, size_f;
    logic [3:0]          szlen_reg, szlen_next;
    logic [2:0]          szleft_reg, szleft_next;
    logic [POS_BITS-1:0] pos_reg, pos_next, npos;
    logic [POS_BITS-1:0] left_reg, left_next, left_dec;
    logic [63:0]         pix_reg, pix_next;
    kind_t               pk_reg, pk_next;

    logic                acc, halt_now, fin, is_cont, is_pix;
    logic [3:0]          len;
    logic [LVL_W-1:0]    level;
    logic [SUM_W-1:0]    sum_x, size_x, max_x;
    logic [1:0]          nres;
    res_t                r0, r1, tmp, head;
    cell_ctl_t           ctl;
    logic                room;
    logic [MAX_DEPTH-1:0] open_v;
    logic [MAX_DEPTH:0]   pop_chain;

    assign acc      = in_valid & in_ready;
    assign in_ready = room;
    assign len      = lead_len(data_byte);
    assign npos     = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_BITS'(1);
    assign left_dec = (left_reg != '0) ? left_reg - POS_BITS'(1) : left_reg;

    always_comb
    begin
        level = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            level = level + LVL_W'(open_v[i]);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        idlen_next  = idlen_reg;
        idleft_next = idleft_reg;
        size_next   = size_reg;
        szlen_next  = szlen_reg;
        szleft_next = szleft_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        pix_next    = pix_reg;
        pk_next     = pk_reg;
        ph_n        = phase_reg;
        halt_now    = 1'b0;
        fin         = 1'b0;
        size_f      = size_reg;
        r0          = '0;
        r1          = '0;
        tmp         = '0;
        nres        = 2'd0;
        ctl         = '0;
        ctl.npos    = npos;
        is_cont     = (id_reg == ID_HEADER) || (id_reg == ID_SEGMENT)
                      || (id_reg == ID_TRACKS) || (id_reg == ID_ENTRY)
                      || (id_reg == ID_VIDEO);
        is_pix      = (id_reg == ID_PIX_W) || (id_reg == ID_PIX_H);
        size_x      = '0;
        sum_x       = '0;
        max_x       = SUM_W'(POS_MAX);
        if (acc && phase_reg != PH_HALT)
        begin
            pos_next = npos;
            unique case (phase_reg)
                PH_ID_FIRST:
                begin
                    if (data_byte < ID_MIN_BYTE)
                    begin
                        r0.kind  = K_BAD_ID;
                        nres     = 2'd1;
                        halt_now = 1'b1;
                    end
                    else
                    begin
                        id_next     = {24'd0, data_byte};
                        idlen_next  = 3'(len);
                        idleft_next = 2'(len - 4'd1);
                        ph_n        = (len == 4'd1) ? PH_SIZE_FIRST : PH_ID_MORE;
                    end
                end
                PH_ID_MORE:
                begin
                    id_next     = {id_reg[23:0], data_byte};
                    idleft_next = idleft_reg - 2'd1;
                    if (idleft_next == 2'd0)
                    begin
                        ph_n = PH_SIZE_FIRST;
                    end
                end
                PH_SIZE_FIRST:
                begin
                    if (data_byte == 8'd0)
                    begin
                        r0.kind  = K_BAD_SIZE;
                        nres     = 2'd1;
                        halt_now = 1'b1;
                    end
                    else
                    begin
                        size_f      = {48'd0, data_byte & (8'hFF >> len)};
                        size_next   = size_f;
                        szlen_next  = len;
                        szleft_next = 3'(len - 4'd1);
                        if (len == 4'd1)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            ph_n = PH_SIZE_MORE;
                        end
                    end
                end
                PH_SIZE_MORE:
                begin
                    size_f      = {size_reg[47:0], data_byte};
                    size_next   = size_f;
                    szleft_next = szleft_reg - 3'd1;
                    if (szleft_next == 3'd0)
                    begin
                        fin = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        ph_n = PH_ID_FIRST;
                    end
                end
                PH_PIXEL:
                begin
                    pix_next  = {pix_reg[55:0], data_byte};
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        r0.kind         = pk_reg;
                        r0.elem_id      = id_reg;
                        r0.id_bytes     = idlen_reg;
                        r0.element_size = size_reg;
                        r0.size_bytes   = szlen_reg;
                        r0.nest_level   = 4'(level);
                        r0.pixel_value  = pix_next;
                        nres            = 2'd1;
                        ph_n            = PH_ID_FIRST;
                    end
                end
                default:
                begin
                    ph_n = PH_ID_FIRST;
                end
            endcase

            if (fin)
            begin
                r0.kind         = K_HEADER;
                r0.elem_id      = id_reg;
                r0.id_bytes     = idlen_reg;
                r0.element_size = size_f;
                r0.size_bytes   = szlen_next;
                r0.nest_level   = 4'(level);
                nres            = 2'd1;
                ph_n            = PH_ID_FIRST;
                size_x          = SUM_W'(size_f);
                sum_x           = SUM_W'(npos) + size_x;
                if (is_cont)
                begin
                    if (open_v[MAX_DEPTH-1])
                    begin
                        r1.kind  = K_DEEP;
                        nres     = 2'd2;
                        halt_now = 1'b1;
                    end
                    else
                    begin
                        ctl.push     = 1'b1;
                        ctl.push_end = (sum_x > max_x) ? POS_MAX
                                                       : sum_x[POS_BITS-1:0];
                    end
                end
                else
                begin
                    left_next = (size_x > max_x) ? POS_MAX : size_x[POS_BITS-1:0];
                    if (is_pix)
                    begin
                        pk_next  = (id_reg == ID_PIX_W) ? K_WIDTH : K_HEIGHT;
                        pix_next = '0;
                        if (size_f == '0)
                        begin
                            r1         = r0;
                            r1.kind    = pk_next;
                            nres       = 2'd2;
                        end
                        else
                        begin
                            ph_n = PH_PIXEL;
                        end
                    end
                    else if (size_f != '0)
                    begin
                        ph_n = PH_SKIP;
                    end
                end
            end

            if (!halt_now)
            begin
                ctl.pop_en = (ph_n == PH_ID_FIRST);
                if (last_byte)
                begin
                    halt_now = 1'b1;
                    if (ph_n == PH_ID_MORE || ph_n == PH_SIZE_FIRST
                        || ph_n == PH_SIZE_MORE || ph_n == PH_PIXEL)
                    begin
                        tmp.kind = K_TRUNC;
                        if (nres == 2'd0)
                        begin
                            r0   = tmp;
                            nres = 2'd1;
                        end
                        else
                        begin
                            r1   = tmp;
                            nres = 2'd2;
                        end
                    end
                end
            end
            phase_next = halt_now ? PH_HALT : ph_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID_FIRST;
            id_reg     <= '0;
            idlen_reg  <= '0;
            idleft_reg <= '0;
            size_reg   <= '0;
            szlen_reg  <= '0;
            szleft_reg <= '0;
            pos_reg    <= '0;
            left_reg   <= '0;
            pix_reg    <= '0;
            pk_reg     <= K_HEADER;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            idlen_reg  <= idlen_next;
            idleft_reg <= idleft_next;
            size_reg   <= size_next;
            szlen_reg  <= szlen_next;
            szleft_reg <= szleft_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            pix_reg    <= pix_next;
            pk_reg     <= pk_next;
        end
    end

    assign pop_chain[MAX_DEPTH] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++)
        begin : g_cell
            ebsp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .below_open ((g == 0) ? 1'b1 : open_v[(g == 0) ? 0 : g - 1]),
                .pop_in     (pop_chain[g+1]),
                .open       (open_v[g]),
                .pop_out    (pop_chain[g])
            );
        end
    endgenerate

    ebsp_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_count  (nres),
        .wr0       (r0),
        .wr1       (r1),
        .rd        (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    assign kind         = head.kind;
    assign elem_id      = head.elem_id;
    assign id_bytes     = head.id_bytes;
    assign element_size = head.element_size;
    assign size_bytes   = head.size_bytes;
    assign nest_level   = head.nest_level;
    assign pixel_value  = head.pixel_value;

    `ASSERT_CLK(a_halt_sticks, (phase_reg == PH_HALT) |=> (phase_reg == PH_HALT), "halt left without reset")
    `ASSERT_CLK(a_stack_thermo, ((open_v + MAX_DEPTH'(1)) & open_v) == '0, "open levels not contiguous")
    `ASSERT_CLK(a_no_push_full, !(ctl.push && open_v[MAX_DEPTH-1]), "push onto a full stack")

endmodule

/* hdl/ebsp_cell.sv */
// One level of the container stack: holds an end position and an open flag.
// Depends on ebsp_pkg; chained by the top level, pop decisions run downwards.
module ebsp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ebsp_pkg::cell_ctl_t ctl,
    input  logic                below_open,
    input  logic                pop_in,
    output logic                open,
    output logic                pop_out
);
    import ebsp_pkg::*;

    logic                open_reg, open_next;
    logic [POS_BITS-1:0] end_reg;
    logic                push_here, open_eff, pops;
    logic [POS_BITS-1:0] end_eff;

    always_comb
    begin
        push_here = ctl.push & below_open & ~open_reg;
        open_eff  = open_reg | push_here;
        end_eff   = push_here ? ctl.push_end : end_reg;
        pops      = ctl.pop_en & open_eff & pop_in & (end_eff <= ctl.npos);
        pop_out   = open_eff ? pops : pop_in;
        open_next = open_eff & ~pops;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_here)
        begin
            end_reg <= ctl.push_end;
        end
    end

    assign open = open_reg;

endmodule

/* hdl/ebsp_res_fifo.sv */
// Result queue: takes up to two results per cycle and hands out one.
// Depends on ebsp_pkg for the result type and the queue depth.
module ebsp_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     wr_count,
    input  ebsp_pkg::res_t wr0,
    input  ebsp_pkg::res_t wr1,
    input  logic           rd,
    output ebsp_pkg::res_t head,
    output logic           not_empty,
    output logic           room
);
    import ebsp_pkg::*;

    res_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   wp_reg, rp_reg;
    logic [FIFO_CW-1:0]   cnt_reg;
    logic                 do_rd;

    assign not_empty = (cnt_reg != '0);
    assign room      = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign head      = mem_reg[rp_reg];
    assign do_rd     = rd & not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + FIFO_PW'(wr_count);
            rp_reg  <= rp_reg + FIFO_PW'(do_rd);
            cnt_reg <= cnt_reg + FIFO_CW'(wr_count) - FIFO_CW'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            mem_reg[wp_reg] <= wr0;
        end
        if (wr_count == 2'd2)
        begin
            mem_reg[wp_reg + FIFO_PW'(1)] <= wr1;
        end
    end

endmodule
